[src/cckb_pkg.sv]
// Package for the clipped color-key sprite blitter.
// Holds the item structs, the register map and the reset constants.
// Used by every module of the block; depends on nothing.
package cckb_pkg;

  localparam logic [12:0] CANVAS_LIMIT = 13'd4096;
  localparam logic [12:0] CANVAS_W_RESET = 13'd1280;
  localparam logic [12:0] CANVAS_H_RESET = 13'd720;
  localparam logic signed [15:0] CAMERA_X_RESET = 16'sd250;

  typedef enum logic [2:0] {
    REG_CANVAS_W,
    REG_CANVAS_H,
    REG_SHEET_STRIDE,
    REG_FRAME_W,
    REG_FRAME_H,
    REG_COLOR_KEY,
    REG_CAMERA_X,
    REG_CAMERA_Y
  } cfg_reg_t;

  typedef enum logic {
    KIND_START,
    KIND_PIXEL
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] world_x;
    logic signed [15:0] world_y;
    logic [23:0]        sheet_offset;
    logic [31:0]        pixel_in;
  } in_item_t;

  typedef struct packed {
    logic        write_enable;
    logic [23:0] dest_index;
    logic [23:0] src_index;
    logic [31:0] pixel_out;
    logic        frame_last;
  } out_item_t;

  // Canvas sizes are already limited to CANVAS_LIMIT; frame sizes are raw.
  typedef struct packed {
    logic [12:0]        canvas_w;
    logic [12:0]        canvas_h;
    logic [12:0]        sheet_stride;
    logic [12:0]        frame_w;
    logic [12:0]        frame_h;
    logic               color_key;
    logic signed [15:0] camera_x;
    logic signed [15:0] camera_y;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic in_canvas;
    logic last;
  } job_ctl_t;

endpackage

[src/clipped_color_key_sprite_blit.sv]
// Top level of the clipped color-key sprite blitter.
// Instantiates cckb_cfg, cckb_walk and cckb_addr; depends on cckb_pkg.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------
//   in      | in_valid / in_ready  | in_item  (start or pixel item)
//   out     | out_valid / out_ready| out_item (one result per pixel item)
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// One item is accepted per clock while in_ready is high. A pixel item goes
// into the input register and moves on to the result register as soon as
// that is free; its result is then held there until out_ready takes it.
// Start items give no result; they load origin and sheet base, rewind counters.
// With out_ready low the result holds and one more item waits in the input
// register, after which in_ready drops. Reset clears all control state.
module clipped_color_key_sprite_blit #(
  parameter int MAX_SIDE   = 4096,
  parameter int PIXEL_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cckb_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cckb_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int CNT_W = $clog2(MAX_SIDE);

  cckb_pkg::cfg_t      cfg;
  cckb_pkg::job_ctl_t  job;
  logic                job_ready;
  logic [11:0]         job_x;
  logic [11:0]         job_y;
  logic [CNT_W-1:0]    job_row;
  logic [CNT_W-1:0]    job_col;
  logic [23:0]         job_base;
  logic [PIXEL_BITS-1:0] job_pix;

  cckb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cckb_walk #(
    .MAX_SIDE   (MAX_SIDE),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .job_ready (job_ready),
    .job       (job),
    .job_x     (job_x),
    .job_y     (job_y),
    .job_row   (job_row),
    .job_col   (job_col),
    .job_base  (job_base),
    .job_pix   (job_pix)
  );

  cckb_addr #(
    .MAX_SIDE   (MAX_SIDE),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_addr (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job       (job),
    .job_ready (job_ready),
    .job_x     (job_x),
    .job_y     (job_y),
    .job_row   (job_row),
    .job_col   (job_col),
    .job_base  (job_base),
    .job_pix   (job_pix),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

[src/cckb_cfg.sv]
// Configuration register file of the sprite blitter.
// Depends on cckb_pkg for the register map and the cfg_t bundle.
module cckb_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output cckb_pkg::cfg_t      cfg
);

  logic [12:0]        canvas_w;
  logic [12:0]        canvas_h;
  logic [12:0]        sheet_stride;
  logic [12:0]        frame_w;
  logic [12:0]        frame_h;
  logic               color_key;
  logic signed [15:0] camera_x;
  logic signed [15:0] camera_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_w     <= cckb_pkg::CANVAS_W_RESET;
      canvas_h     <= cckb_pkg::CANVAS_H_RESET;
      sheet_stride <= 13'd1;
      frame_w      <= 13'd1;
      frame_h      <= 13'd1;
      color_key    <= 1'b0;
      camera_x     <= cckb_pkg::CAMERA_X_RESET;
      camera_y     <= 16'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cckb_pkg::cfg_reg_t'(cfg_index))
        cckb_pkg::REG_CANVAS_W:     canvas_w     <= cfg_data[12:0];
        cckb_pkg::REG_CANVAS_H:     canvas_h     <= cfg_data[12:0];
        cckb_pkg::REG_SHEET_STRIDE: sheet_stride <= cfg_data[12:0];
        cckb_pkg::REG_FRAME_W:      frame_w      <= cfg_data[12:0];
        cckb_pkg::REG_FRAME_H:      frame_h      <= cfg_data[12:0];
        cckb_pkg::REG_COLOR_KEY:    color_key    <= cfg_data[0];
        cckb_pkg::REG_CAMERA_X:     camera_x     <= $signed(cfg_data);
        cckb_pkg::REG_CAMERA_Y:     camera_y     <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // A canvas of zero stays zero, so that no pixel ever lands inside it.
  always_comb begin
    cfg.canvas_w = (canvas_w > cckb_pkg::CANVAS_LIMIT) ? cckb_pkg::CANVAS_LIMIT : canvas_w;
    cfg.canvas_h = (canvas_h > cckb_pkg::CANVAS_LIMIT) ? cckb_pkg::CANVAS_LIMIT : canvas_h;
    cfg.sheet_stride = sheet_stride;
    cfg.frame_w      = frame_w;
    cfg.frame_h      = frame_h;
    cfg.color_key    = color_key;
    cfg.camera_x     = camera_x;
    cfg.camera_y     = camera_y;
  end

endmodule

[src/cckb_walk.sv]
// Frame walker: origin and sheet base from start items, column and row
// counters, clip test, and the input register that feeds the address stage.
// Depends on cckb_pkg.
module cckb_walk #(
  parameter int MAX_SIDE   = 4096,
  parameter int PIXEL_BITS = 32,
  localparam int CNT_W     = $clog2(MAX_SIDE)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cckb_pkg::cfg_t            cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  cckb_pkg::in_item_t        in_item,
  input  logic                      job_ready,
  output cckb_pkg::job_ctl_t        job,
  output logic [11:0]               job_x,
  output logic [11:0]               job_y,
  output logic [CNT_W-1:0]          job_row,
  output logic [CNT_W-1:0]          job_col,
  output logic [23:0]               job_base,
  output logic [PIXEL_BITS-1:0]     job_pix
);

  localparam logic [13:0] SIDE_MAX = 14'(MAX_SIDE);

  logic [CNT_W-1:0] col;
  logic [CNT_W-1:0] row;
  logic [16:0]      origin_x;
  logic [16:0]      origin_y;
  logic [23:0]      frame_base;
  logic             job_valid;
  logic             job_inside;
  logic             job_last;

  logic [13:0]      fw;
  logic [13:0]      fh;
  logic [CNT_W-1:0] col_eff;
  logic [CNT_W-1:0] row_eff;
  logic [13:0]      col_inc;
  logic [13:0]      row_inc;
  logic [CNT_W-1:0] col_next;
  logic [CNT_W-1:0] row_next;
  logic [17:0]      dx;
  logic [17:0]      dy;
  logic             in_canvas;
  logic             last;
  logic             start_acc;
  logic             pix_acc;

  assign in_ready  = !job_valid || job_ready;
  assign start_acc = in_valid && in_ready && (in_item.kind == cckb_pkg::KIND_START);
  assign pix_acc   = in_valid && in_ready && (in_item.kind == cckb_pkg::KIND_PIXEL);

  always_comb begin
    // A frame side of zero acts as one; a side beyond MAX_SIDE acts as MAX_SIDE.
    if (cfg.frame_w == 13'd0) fw = 14'd1;
    else if ({1'b0, cfg.frame_w} > SIDE_MAX) fw = SIDE_MAX;
    else fw = {1'b0, cfg.frame_w};
    if (cfg.frame_h == 13'd0) fh = 14'd1;
    else if ({1'b0, cfg.frame_h} > SIDE_MAX) fh = SIDE_MAX;
    else fh = {1'b0, cfg.frame_h};

    // Counters left beyond a frame that has since shrunk restart at zero.
    col_eff = (14'(col) >= fw) ? '0 : col;
    row_eff = (14'(row) >= fh) ? '0 : row;
    col_inc = 14'(col_eff) + 14'd1;
    row_inc = 14'(row_eff) + 14'd1;
    last    = (col_inc == fw) && (row_inc == fh);

    if (col_inc >= fw) begin
      col_next = '0;
      row_next = (row_inc >= fh) ? '0 : CNT_W'(row_inc);
    end else begin
      col_next = CNT_W'(col_inc);
      row_next = row_eff;
    end

    dx = {origin_x[16], origin_x} + 18'(col_eff);
    dy = {origin_y[16], origin_y} + 18'(row_eff);
    in_canvas = !dx[17] && !dy[17]
                && (dx < {5'b0, cfg.canvas_w}) && (dy < {5'b0, cfg.canvas_h});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      origin_x   <= '0;
      origin_y   <= '0;
      frame_base <= '0;
      job_valid  <= 1'b0;
    end else begin
      if (start_acc) begin
        origin_x   <= {in_item.world_x[15], in_item.world_x}
                      - {cfg.camera_x[15], cfg.camera_x};
        origin_y   <= {in_item.world_y[15], in_item.world_y}
                      - {cfg.camera_y[15], cfg.camera_y};
        frame_base <= in_item.sheet_offset;
        col        <= '0;
        row        <= '0;
      end else if (pix_acc) begin
        col <= col_next;
        row <= row_next;
      end
      if (pix_acc) job_valid <= 1'b1;
      else if (job_ready) job_valid <= 1'b0;
    end
  end

  // Only the low twelve bits of the canvas position matter once it is inside.
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      job_inside <= in_canvas;
      job_last   <= last;
      job_x      <= dx[11:0];
      job_y      <= dy[11:0];
      job_row    <= row_eff;
      job_col    <= col_eff;
      job_base   <= frame_base;
      job_pix    <= in_item.pixel_in[PIXEL_BITS-1:0];
    end
  end

  assign job = '{valid: job_valid, in_canvas: job_inside, last: job_last};

  a_start_rewinds: assert property (@(posedge clk) disable iff (rst)
    start_acc |=> (col == '0) && (row == '0))
    else $error("counters not rewound after a start item");

  a_pixel_enters: assert property (@(posedge clk) disable iff (rst)
    pix_acc |=> job_valid)
    else $error("accepted pixel item did not reach the input register");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !job_ready) |=> job_valid && $stable(job_col) && $stable(job_row))
    else $error("input register changed while the address stage was stalled");

endmodule

[src/cckb_addr.sv]
// Address stage: canvas index, saturating sheet index, color key test,
// and the result register. Depends on cckb_pkg.
module cckb_addr #(
  parameter int MAX_SIDE   = 4096,
  parameter int PIXEL_BITS = 32,
  localparam int CNT_W     = $clog2(MAX_SIDE)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cckb_pkg::cfg_t            cfg,
  input  cckb_pkg::job_ctl_t        job,
  output logic                      job_ready,
  input  logic [11:0]               job_x,
  input  logic [11:0]               job_y,
  input  logic [CNT_W-1:0]          job_row,
  input  logic [CNT_W-1:0]          job_col,
  input  logic [23:0]               job_base,
  input  logic [PIXEL_BITS-1:0]     job_pix,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cckb_pkg::out_item_t       out_item
);

  logic [24:0]          prod_d;
  logic [26:0]          prod_s;
  logic [26:0]          sum_s;
  cckb_pkg::out_item_t  res;
  logic                 load;

  assign job_ready = !out_valid || out_ready;
  assign load      = job.valid && job_ready;

  always_comb begin
    prod_d = {13'b0, job_y} * {12'b0, cfg.canvas_w};
    prod_s = 27'(job_row) * 27'(cfg.sheet_stride);
    sum_s  = {3'b0, job_base} + prod_s + 27'(job_col);

    res.dest_index   = job.in_canvas ? (prod_d[23:0] + {12'b0, job_x}) : 24'd0;
    res.src_index    = (sum_s[26:24] != 3'b0) ? 24'hFFFFFF : sum_s[23:0];
    res.pixel_out    = 32'(job_pix);
    res.write_enable = job.in_canvas && !(cfg.color_key && (job_pix == '0));
    res.frame_last   = job.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= res;
    end
  end

  a_job_lands: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("item from the input register did not reach the result register");

  a_write_in_canvas: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.write_enable)
      |-> ({2'b0, out_item.dest_index} < (26'(cfg.canvas_w) * 26'(cfg.canvas_h))))
    else $error("write enabled outside the canvas");

  a_color_key: assert property (@(posedge clk) disable iff (rst)
    (out_valid && cfg.color_key && (out_item.pixel_out == 32'd0))
      |-> !out_item.write_enable)
    else $error("keyed pixel was written");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the clipped color-key sprite blitter.
// Holds its own pixel predictor, directed tests and random frame traffic;
// depends on cckb_pkg and clipped_color_key_sprite_blit.
module tb_top;

  localparam int MAX_SIDE = 4096;
  localparam int PIXEL_BITS = 32;
  localparam logic [31:0] PIXEL_MASK =
    (PIXEL_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << PIXEL_BITS) - 32'd1);
  localparam longint INDEX_MAX = 64'd16777215;
  localparam int RANDOM_ITEMS = 1550;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  cckb_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cckb_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  clipped_color_key_sprite_blit #(
    .MAX_SIDE(MAX_SIDE),
    .PIXEL_BITS(PIXEL_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies, as written, and the blit position state.
  logic [12:0] canvas_w_q = 13'd1280;
  logic [12:0] canvas_h_q = 13'd720;
  logic [12:0] sheet_stride_q = 13'd1;
  logic [12:0] frame_w_q = 13'd1;
  logic [12:0] frame_h_q = 13'd1;
  logic color_key_q = 1'b0;
  logic signed [15:0] camera_x_q = 16'sd250;
  logic signed [15:0] camera_y_q = 16'sd0;
  int blit_col = 0;
  int blit_row = 0;
  int org_x = 0;
  int org_y = 0;
  logic [23:0] sheet_base = '0;

  cckb_pkg::out_item_t pending_pixels[$];
  logic no_stall = 1'b0;
  int items_sent = 0;
  int starts_sent = 0;
  int pixels_checked = 0;
  int pixels_written = 0;
  int frames_closed = 0;
  int settings_applied = 0;
  int mismatches = 0;

  function automatic int eff_frame_side(logic [12:0] v);
    if (v == 0) return 1;
    return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
  endfunction

  function automatic int eff_canvas_side(logic [12:0] v);
    return (v > cckb_pkg::CANVAS_LIMIT) ? int'(cckb_pkg::CANVAS_LIMIT) : int'(v);
  endfunction

  // Works out the result of one pixel item and advances the frame position.
  function automatic cckb_pkg::out_item_t blit_pixel(logic [31:0] raw);
    int fw, fh, cw, ch, dx, dy;
    longint src;
    logic [31:0] pix;
    logic in_canvas;
    cckb_pkg::out_item_t r;
    fw = eff_frame_side(frame_w_q);
    fh = eff_frame_side(frame_h_q);
    cw = eff_canvas_side(canvas_w_q);
    ch = eff_canvas_side(canvas_h_q);
    if (blit_col >= fw) blit_col = 0;
    if (blit_row >= fh) blit_row = 0;
    pix = raw & PIXEL_MASK;
    dx = org_x + blit_col;
    dy = org_y + blit_row;
    in_canvas = (dx >= 0) && (dy >= 0) && (dx < cw) && (dy < ch);
    r.write_enable = in_canvas && !(color_key_q && pix == 32'd0);
    r.dest_index = in_canvas ? 24'(dy * cw + dx) : 24'd0;
    src = longint'(sheet_base) + longint'(blit_row) * longint'(sheet_stride_q)
          + longint'(blit_col);
    r.src_index = (src > INDEX_MAX) ? 24'hFF_FFFF : 24'(src);
    r.pixel_out = pix;
    r.frame_last = (blit_col == fw - 1) && (blit_row == fh - 1);
    if (blit_col + 1 >= fw) begin
      blit_col = 0;
      blit_row = (blit_row + 1 >= fh) ? 0 : blit_row + 1;
    end else begin
      blit_col++;
    end
    return r;
  endfunction

  function automatic void note_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  function automatic void check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      note_error($sformatf("pixel result %0d, %s: expected %h, got %h",
                           pixels_checked, name, want, got));
  endfunction

  always @(posedge clk) begin
    cckb_pkg::out_item_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_pixels.size() == 0) begin
        note_error($sformatf("result %h arrived with nothing expected", out_item));
      end else begin
        want = pending_pixels.pop_front();
        check_field("write_enable", 32'(out_item.write_enable), 32'(want.write_enable));
        check_field("dest_index", 32'(out_item.dest_index), 32'(want.dest_index));
        check_field("src_index", 32'(out_item.src_index), 32'(want.src_index));
        check_field("pixel_out", out_item.pixel_out, want.pixel_out);
        check_field("frame_last", 32'(out_item.frame_last), 32'(want.frame_last));
      end
      pixels_checked++;
      if (out_item.write_enable) pixels_written++;
      if (out_item.frame_last) frames_closed++;
    end
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= no_stall || ($urandom_range(99) >= 36);
  end

  // Sends one item after a random idle gap and updates the predictor when it
  // is accepted. Valid stays high on return so a back-to-back item follows.
  task automatic send_item(cckb_pkg::in_item_t it);
    int gap;
    gap = 0;
    while (!no_stall && $urandom_range(99) < 36) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.kind == cckb_pkg::KIND_START) begin
      org_x = int'($signed(it.world_x)) - int'(camera_x_q);
      org_y = int'($signed(it.world_y)) - int'(camera_y_q);
      sheet_base = it.sheet_offset;
      blit_col = 0;
      blit_row = 0;
      starts_sent++;
    end else begin
      pending_pixels.push_back(blit_pixel(it.pixel_in));
    end
    items_sent++;
  endtask

  task automatic send_start(logic signed [15:0] wx, logic signed [15:0] wy,
                            logic [23:0] offset);
    cckb_pkg::in_item_t it;
    it.kind = cckb_pkg::KIND_START;
    it.world_x = wx;
    it.world_y = wy;
    it.sheet_offset = offset;
    it.pixel_in = $urandom;
    send_item(it);
  endtask

  task automatic send_pixel(logic [31:0] pix);
    cckb_pkg::in_item_t it;
    it.kind = cckb_pkg::KIND_PIXEL;
    it.world_x = 16'($urandom);
    it.world_y = 16'($urandom);
    it.sheet_offset = 24'($urandom);
    it.pixel_in = pix;
    send_item(it);
  endtask

  // Lowers valid and lets the block drain before any register write.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(cckb_pkg::cfg_reg_t idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      cckb_pkg::REG_CANVAS_W:     canvas_w_q = data[12:0];
      cckb_pkg::REG_CANVAS_H:     canvas_h_q = data[12:0];
      cckb_pkg::REG_SHEET_STRIDE: sheet_stride_q = data[12:0];
      cckb_pkg::REG_FRAME_W:      frame_w_q = data[12:0];
      cckb_pkg::REG_FRAME_H:      frame_h_q = data[12:0];
      cckb_pkg::REG_COLOR_KEY:    color_key_q = data[0];
      cckb_pkg::REG_CAMERA_X:     camera_x_q = data;
      cckb_pkg::REG_CAMERA_Y:     camera_y_q = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Unused upper data bits are filled at random; the block must ignore them.
  task automatic program_all(logic [12:0] cw, logic [12:0] ch, logic [12:0] stride,
                             logic [12:0] fw, logic [12:0] fh, logic ck,
                             logic signed [15:0] cx, logic signed [15:0] cy);
    write_reg(cckb_pkg::REG_CANVAS_W, {3'($urandom), cw});
    write_reg(cckb_pkg::REG_CANVAS_H, {3'($urandom), ch});
    write_reg(cckb_pkg::REG_SHEET_STRIDE, {3'($urandom), stride});
    write_reg(cckb_pkg::REG_FRAME_W, {3'($urandom), fw});
    write_reg(cckb_pkg::REG_FRAME_H, {3'($urandom), fh});
    write_reg(cckb_pkg::REG_COLOR_KEY, {15'($urandom), ck});
    write_reg(cckb_pkg::REG_CAMERA_X, cx);
    write_reg(cckb_pkg::REG_CAMERA_Y, cy);
    settings_applied++;
  endtask

  // Reset origin and base apply until the first start item.
  task automatic test_before_start();
    send_pixel(32'd0);
    send_pixel(32'hFFFF_FFFF);
  endtask

  // A 2x2 frame hanging over the top-left corner, then the bottom-right one.
  task automatic test_clipping();
    wait_idle();
    program_all(13'd5, 13'd4, 13'd16, 13'd2, 13'd2, 1'b0, -16'sd3, 16'sd2);
    send_start(-16'sd4, 16'sd1, 24'd100);
    repeat (4) send_pixel($urandom);
    send_start(16'sd1, 16'sd5, 24'd200);
    repeat (4) send_pixel($urandom);
  endtask

  // Zero frame sizes act as one, so every pixel wraps back to the first.
  task automatic test_color_key_and_wrap();
    wait_idle();
    program_all(13'd1280, 13'd720, 13'd1, 13'd0, 13'd0, 1'b1, 16'sd250, 16'sd0);
    send_start(16'sd260, 16'sd5, 24'd7);
    send_pixel(32'd0);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'd1);
  endtask

  // Oversized canvas, the largest canvas index and a saturating sheet index.
  task automatic test_index_limits();
    wait_idle();
    program_all(13'd8191, 13'd4096, 13'd8191, 13'd2, 13'd2, 1'b1, 16'sd0, 16'sd0);
    send_start(16'sd4094, 16'sd4094, 24'hFF_FFFE);
    repeat (4) send_pixel($urandom | 32'h1);
  endtask

  // Extreme camera and world positions, oversized frame and an empty canvas.
  task automatic test_far_positions();
    wait_idle();
    program_all(13'd0, 13'd4096, 13'd0, 13'd8191, 13'd4096, 1'b0,
                16'sh7FFF, 16'sh8000);
    send_start(16'sh8000, 16'sh7FFF, 24'd0);
    send_pixel($urandom);
    send_start(16'sh7FFF, 16'sh8000, 24'hAB_CDEF);
    send_pixel(32'd0);
  endtask

  function automatic logic [12:0] pick_canvas_side();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 13'd0;
    if (r < 10) return 13'd4096;
    if (r < 15) return 13'($urandom_range(4097, 8191));
    if (r < 22) return 13'($urandom_range(1, 4095));
    return 13'($urandom_range(1, 48));
  endfunction

  function automatic logic [12:0] pick_frame_side();
    int r;
    r = $urandom_range(99);
    if (r < 6) return 13'd0;
    if (r < 12) return 13'($urandom_range(4096, 8191));
    if (r < 16) return 13'($urandom_range(9, 4095));
    return 13'($urandom_range(1, 8));
  endfunction

  // Canvas offset of a frame: mostly across the near or far edge.
  function automatic int pick_offset(int extent, int side);
    int r;
    r = $urandom_range(99);
    if (r < 35) return int'($urandom_range(0, extent + 2)) - extent - 1;
    if (r < 70) return side - extent - 1 + int'($urandom_range(0, extent + 2));
    if (r < 90) return int'($urandom_range(0, side));
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic logic [23:0] pick_sheet_offset();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 24'($urandom_range(0, 4095));
    if (r < 85) return 24'hFF_FFFF - 24'($urandom_range(0, 64));
    return 24'($urandom);
  endfunction

  function automatic logic [31:0] pick_pixel();
    return ($urandom_range(99) < 25) ? 32'd0 : 32'($urandom);
  endfunction

  task automatic start_random_frame(int fw_e, int fh_e, int cw_e, int ch_e);
    int ox, oy;
    ox = pick_offset(fw_e > 64 ? 64 : fw_e, cw_e);
    oy = pick_offset(fh_e > 64 ? 64 : fh_e, ch_e);
    send_start(16'(int'(camera_x_q) + ox), 16'(int'(camera_y_q) + oy),
               pick_sheet_offset());
  endtask

  // Phases of random settings, each carrying a few frames. Most frames are
  // complete; some are cut short, overrun, restarted or have stray pixels.
  task automatic test_random_frames();
    int first, shape, n_full, n_pix, fw_e, fh_e, cw_e, ch_e;
    logic signed [15:0] cx, cy;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      wait_idle();
      no_stall = (items_sent - first >= 450) && (items_sent - first < 800);
      if ($urandom_range(1) == 0) begin
        cx = 16'(int'($urandom_range(0, 600)) - 300);
        cy = 16'(int'($urandom_range(0, 600)) - 300);
      end else begin
        cx = 16'($urandom);
        cy = 16'($urandom);
      end
      program_all(pick_canvas_side(), pick_canvas_side(),
                  ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 40)),
                  pick_frame_side(), pick_frame_side(), 1'($urandom), cx, cy);
      fw_e = eff_frame_side(frame_w_q);
      fh_e = eff_frame_side(frame_h_q);
      cw_e = eff_canvas_side(canvas_w_q);
      ch_e = eff_canvas_side(canvas_h_q);
      n_full = fw_e * fh_e;
      repeat ($urandom_range(3, 8)) begin
        if (n_full > 48) n_pix = $urandom_range(1, 40);
        else n_pix = n_full;
        shape = $urandom_range(99);
        if (shape < 75) begin
          start_random_frame(fw_e, fh_e, cw_e, ch_e);
        end else if (shape < 85) begin
          start_random_frame(fw_e, fh_e, cw_e, ch_e);
          n_pix = $urandom_range(0, n_pix - 1);
        end else if (shape < 93) begin
          start_random_frame(fw_e, fh_e, cw_e, ch_e);
          n_pix = n_pix + $urandom_range(1, n_pix);
        end else if (shape < 97) begin
          start_random_frame(fw_e, fh_e, cw_e, ch_e);
          start_random_frame(fw_e, fh_e, cw_e, ch_e);
          n_pix = $urandom_range(1, 4);
        end else begin
          n_pix = $urandom_range(1, 4);
        end
        repeat (n_pix) send_pixel(pick_pixel());
      end
    end
    no_stall = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_before_start();
    test_clipping();
    test_color_key_and_wrap();
    test_index_limits();
    test_far_positions();
    test_random_frames();
    wait_idle();
    $display("Sent %0d items (%0d frame starts) under %0d register settings.",
             items_sent, starts_sent, settings_applied);
    $display("Checked %0d pixel results: %0d written, %0d closing a frame, %0d mismatches.",
             pixels_checked, pixels_written, frames_closed, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still expected.", pending_pixels.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[clipped_color_key_sprite_blit.f]
src/cckb_pkg.sv
src/cckb_cfg.sv
src/cckb_walk.sv
src/cckb_addr.sv
src/clipped_color_key_sprite_blit.sv
sim/tb_top.sv
